[sv/famr_pkg.sv]
package famr_pkg;

	localparam int OPERAND_BITS_DEF = 16;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_MUL = 1'b1;

	typedef enum logic [1:0] {
		MUL_FIRST = 2'd0,
		MUL_CROSS = 2'd1,
		MUL_DEN   = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic     capture;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     num_ld;
		logic     num_acc;
		logic     gcd_init;
		logic     gcd_step;
		logic     div_init;
		logic     div_step;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic gcd_done;
	} status_t;

endpackage

[sv/famr_if.sv]
interface famr_in_if #(
	parameter int N = famr_pkg::OPERAND_BITS_DEF
);
	logic         valid;
	logic         ready;
	logic         opcode;
	logic [N-1:0] a_numerator;
	logic [N-1:0] a_denominator;
	logic [N-1:0] b_numerator;
	logic [N-1:0] b_denominator;

	modport source (
		output valid, opcode, a_numerator, a_denominator, b_numerator, b_denominator,
		input  ready
	);
	modport sink (
		input  valid, opcode, a_numerator, a_denominator, b_numerator, b_denominator,
		output ready
	);
endinterface

interface famr_out_if #(
	parameter int N = famr_pkg::OPERAND_BITS_DEF
);
	logic           valid;
	logic           ready;
	logic [2*N:0]   result_numerator;
	logic [2*N-1:0] result_denominator;
	logic           bad_input;

	modport source (
		output valid, result_numerator, result_denominator, bad_input,
		input  ready
	);
	modport sink (
		input  valid, result_numerator, result_denominator, bad_input,
		output ready
	);
endinterface

[sv/famr_dp.sv]
module famr_dp #(
	parameter int OPERAND_BITS = famr_pkg::OPERAND_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  famr_pkg::cmd_t            cmd,
	output famr_pkg::status_t         status,
	input  logic                      opcode,
	input  logic [OPERAND_BITS-1:0]   a_numerator,
	input  logic [OPERAND_BITS-1:0]   a_denominator,
	input  logic [OPERAND_BITS-1:0]   b_numerator,
	input  logic [OPERAND_BITS-1:0]   b_denominator,
	output logic [2*OPERAND_BITS:0]   result_numerator,
	output logic [2*OPERAND_BITS-1:0] result_denominator,
	output logic                      bad_input
);

	localparam int N  = OPERAND_BITS;
	localparam int PW = 2 * N;
	localparam int W  = 2 * N + 1;
	localparam int KW = $clog2(W);

	logic          op_q;
	logic [N-1:0]  an_q, ad_q, bn_q, bd_q;
	logic          bad_q;
	logic [PW-1:0] prod_q;
	logic [W-1:0]  num_q;
	logic [PW-1:0] den_q;
	logic [W-1:0]  u_q, v_q;
	logic [KW-1:0] k_q;
	logic [W-1:0]  g_q;
	logic [W-1:0]  rem_n_q, rem_d_q, dvd_n_q, dvd_d_q;
	logic [W:0]    trial_n, trial_d, sub_n, sub_d;
	logic          ge_n, ge_d;
	logic [N-1:0]  mx, my;
	logic          skip;

	// operand capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= opcode;
			an_q  <= a_numerator;
			ad_q  <= a_denominator;
			bn_q  <= b_numerator;
			bd_q  <= b_denominator;
			bad_q <= (a_denominator == '0) || (b_denominator == '0);
		end
	end

	always_comb begin
		mx = '0;
		my = '0;
		unique case (cmd.mul_sel)
			famr_pkg::MUL_FIRST: begin
				mx = an_q;
				my = (op_q == famr_pkg::OP_ADD) ? bd_q : bn_q;
			end
			famr_pkg::MUL_CROSS: begin
				mx = (op_q == famr_pkg::OP_ADD) ? ad_q : '0;
				my = bn_q;
			end
			famr_pkg::MUL_DEN: begin
				mx = ad_q;
				my = bd_q;
			end
			default: begin
				mx = '0;
				my = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en)
			prod_q <= PW'(mx) * PW'(my);
		if (cmd.num_ld)
			num_q <= W'(prod_q);
		else if (cmd.num_acc)
			num_q <= num_q + W'(prod_q);
	end

	assign skip   = bad_q || (num_q == '0);
	assign status = '{skip: skip, gcd_done: (u_q == '0) || (v_q == '0)};

	// binary gcd, one step per cycle
	always_ff @(posedge clk) begin
		if (cmd.gcd_init) begin
			den_q <= prod_q;
			u_q   <= num_q;
			v_q   <= W'(prod_q);
			k_q   <= '0;
		end else if (cmd.gcd_step) begin
			if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + KW'(1);
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end
	end

	// restoring division of numerator and denominator by the gcd
	assign trial_n = {rem_n_q, dvd_n_q[W-1]};
	assign trial_d = {rem_d_q, dvd_d_q[W-1]};
	assign ge_n    = trial_n >= {1'b0, g_q};
	assign ge_d    = trial_d >= {1'b0, g_q};
	assign sub_n   = ge_n ? (trial_n - {1'b0, g_q}) : trial_n;
	assign sub_d   = ge_d ? (trial_d - {1'b0, g_q}) : trial_d;

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			g_q     <= (u_q | v_q) << k_q;
			rem_n_q <= '0;
			rem_d_q <= '0;
			dvd_n_q <= num_q;
			dvd_d_q <= W'(den_q);
		end else if (cmd.div_step) begin
			rem_n_q <= sub_n[W-1:0];
			rem_d_q <= sub_d[W-1:0];
			dvd_n_q <= {dvd_n_q[W-2:0], ge_n};
			dvd_d_q <= {dvd_d_q[W-2:0], ge_d};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result_numerator   <= skip ? '0 : dvd_n_q;
			result_denominator <= skip ? PW'(1) : dvd_d_q[PW-1:0];
			bad_input          <= bad_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_gcd_operands_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gcd_step |-> (u_q != '0) && (v_q != '0))
		else $error("gcd stepped with a zero operand");
	a_div_rem_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (g_q != '0) && (rem_n_q < g_q) && (rem_d_q < g_q))
		else $error("division remainder out of range");
`endif

endmodule

[sv/famr_ctrl.sv]
module famr_ctrl #(
	parameter int OPERAND_BITS = famr_pkg::OPERAND_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	output logic              res_valid,
	input  logic              res_ready,
	output famr_pkg::cmd_t    cmd,
	input  famr_pkg::status_t status
);

	localparam int W  = 2 * OPERAND_BITS + 1;
	localparam int CW = $clog2(W);
	localparam logic [CW-1:0] DIV_LAST = CW'(W - 1);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_MUL0  = 9'b000000010,
		ST_MUL1  = 9'b000000100,
		ST_MUL2  = 9'b000001000,
		ST_INIT  = 9'b000010000,
		ST_GCD   = 9'b000100000,
		ST_GLOAD = 9'b001000000,
		ST_DIV   = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t        state_q, state_nxt;
	logic [CW-1:0] cnt_q;
	logic          res_valid_q;
	logic          out_free;

	assign item_ready = (state_q == ST_IDLE);
	assign res_valid  = res_valid_q;
	assign out_free   = !res_valid_q || res_ready;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.mul_sel = famr_pkg::MUL_FIRST;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = item_valid;
				if (item_valid)
					state_nxt = ST_MUL0;
			end
			ST_MUL0: begin
				cmd.mul_en = 1'b1;
				state_nxt  = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = famr_pkg::MUL_CROSS;
				cmd.num_ld  = 1'b1;
				state_nxt   = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = famr_pkg::MUL_DEN;
				cmd.num_acc = 1'b1;
				state_nxt   = ST_INIT;
			end
			ST_INIT: begin
				cmd.gcd_init = 1'b1;
				state_nxt    = status.skip ? ST_DONE : ST_GCD;
			end
			ST_GCD: begin
				if (status.gcd_done)
					state_nxt = ST_GLOAD;
				else
					cmd.gcd_step = 1'b1;
			end
			ST_GLOAD: begin
				cmd.div_init = 1'b1;
				state_nxt    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0)
					state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_GLOAD)
				cnt_q <= DIV_LAST;
			else if (state_q == ST_DIV)
				cnt_q <= cnt_q - CW'(1);
			if (cmd.out_load)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && item_valid |=> (state_q == ST_MUL0))
		else $error("accepted transaction did not start multiply");
	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) && (cnt_q == '0) |=> (state_q == ST_DONE))
		else $error("division did not finish on last step");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> res_valid_q && (state_q == ST_IDLE))
		else $error("result load lost");
`endif

endmodule

[sv/fraction_add_multiply_reduce.sv]
// channel   modport  transaction
// operands  sink     opcode, a_numerator, a_denominator, b_numerator, b_denominator
// reduced   source   result_numerator, result_denominator, bad_input
//
// One transaction at a time; its length is set by the one-step binary GCD loop and
// the bit-serial divider, and a zero denominator or zero numerator skips both.
// arst_n clears the controller and the result valid; payload registers are not reset.
// The result register lets the next transaction enter while a result waits;
// a stalled result holds the controller in its last state.
module fraction_add_multiply_reduce #(
	parameter int OPERAND_BITS = famr_pkg::OPERAND_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	famr_in_if.sink      operands,
	famr_out_if.source   reduced
);

	famr_pkg::cmd_t    cmd;
	famr_pkg::status_t status;

	famr_ctrl #(.OPERAND_BITS(OPERAND_BITS)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (operands.valid),
		.item_ready (operands.ready),
		.res_valid  (reduced.valid),
		.res_ready  (reduced.ready),
		.cmd        (cmd),
		.status     (status)
	);

	famr_dp #(.OPERAND_BITS(OPERAND_BITS)) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.opcode             (operands.opcode),
		.a_numerator        (operands.a_numerator),
		.a_denominator      (operands.a_denominator),
		.b_numerator        (operands.b_numerator),
		.b_denominator      (operands.b_denominator),
		.result_numerator   (reduced.result_numerator),
		.result_denominator (reduced.result_denominator),
		.bad_input          (reduced.bad_input)
	);

endmodule
